>>> rtl/core/bsd_pkg.sv
package bsd_pkg;

   localparam int BSD_MAX_COLS  = 1024;
   localparam int BSD_MAX_SCALE = 8;

   // output rows are capped independently of the column memory
   localparam int ROW_CAP = 1024;
   localparam int ROW_W   = 10;

   localparam int GRAD_W  = 16;
   localparam int SUM_W   = 22;
   localparam int SCALE_W = 4;
   localparam int DIM_W   = 11;
   localparam int CSR_W   = 11;
   localparam int CSR_IDX_W = 2;

   localparam int SCALE_RESET  = 2;
   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE,
      CSR_OUT_WIDTH,
      CSR_OUT_HEIGHT
   } bsd_csr_type;

   typedef struct packed {
      logic col_end;
      logic row_end;
      logic first_row;
      logic plane_last;
   } bsd_flags_type;

endpackage

>>> rtl/core/block_sum_downsample.sv
// path: a block-closing request is registered in stage one, its sum then on rsp
// throughput: one request per cycle unless a held rsp stalls stage one, set by
// at most one read-modify-write of the column partial-sum memory per
// request, with same-edge write forwarding
// reset: counters, running sum and registers return to scale 2, 1024 x 1024;
// the partial-sum memory is not cleared and needs no clearing pass
module block_sum_downsample import bsd_pkg::*; #(
   parameter int MAX_COLS  = BSD_MAX_COLS,
   parameter int MAX_SCALE = BSD_MAX_SCALE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [GRAD_W-1:0] req_grad_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SUM_W-1:0]  rsp_block_sum,
   output logic                     rsp_plane_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   localparam int SubW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ScaleRstM1 = ((SCALE_RESET > MAX_SCALE) ? MAX_SCALE : SCALE_RESET) - 1;
   localparam int WidthRstM1 = ((WIDTH_RESET > MAX_COLS) ? MAX_COLS : WIDTH_RESET) - 1;
   localparam int HeightRstM1 = HEIGHT_RESET - 1;

   logic [SubW-1:0]  scale_m1_ff, scale_m1_in;
   logic [ColW-1:0]  width_m1_ff, width_m1_in;
   logic [ROW_W-1:0] height_m1_ff, height_m1_in;
   logic [SCALE_W-1:0] csr_scale;
   logic [DIM_W-1:0]   csr_dim;

   logic                    accept;
   logic [ColW-1:0]         cur_col;
   bsd_flags_type           cur_flags;
   logic signed [SUM_W-1:0] run_sum;

   logic                    s1_valid_ff, s1_valid_in;
   logic [ColW-1:0]         s1_col_ff;
   bsd_flags_type           s1_flags_ff;
   logic                    s1_emit, s1_adv, out_free;
   logic signed [SUM_W-1:0] total;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic                    rsp_last_ff;

   // register writes, stored already clamped and less one
   always_comb begin
      csr_scale    = csr_wdata[SCALE_W-1:0];
      csr_dim      = csr_wdata[DIM_W-1:0];
      scale_m1_in  = scale_m1_ff;
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      if (csr_wr_en) begin
         case (bsd_csr_type'(csr_index))
            CSR_SCALE: begin
               if (csr_scale == '0) scale_m1_in = '0;
               else if (int'(csr_scale) > MAX_SCALE) scale_m1_in = SubW'(MAX_SCALE - 1);
               else scale_m1_in = SubW'(csr_scale - SCALE_W'(1));
            end
            CSR_OUT_WIDTH: begin
               if (csr_dim == '0) width_m1_in = '0;
               else if (int'(csr_dim) > MAX_COLS) width_m1_in = ColW'(MAX_COLS - 1);
               else width_m1_in = ColW'(csr_dim - DIM_W'(1));
            end
            CSR_OUT_HEIGHT: begin
               if (csr_dim == '0) height_m1_in = '0;
               else if (int'(csr_dim) > ROW_CAP) height_m1_in = ROW_W'(ROW_CAP - 1);
               else height_m1_in = ROW_W'(csr_dim - DIM_W'(1));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_m1_ff  <= SubW'(ScaleRstM1);
         width_m1_ff  <= ColW'(WidthRstM1);
         height_m1_ff <= ROW_W'(HeightRstM1);
      end else begin
         scale_m1_ff  <= scale_m1_in;
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
      end
   end

   // pipeline control
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      s1_emit      = s1_flags_ff.col_end && s1_flags_ff.row_end;
      s1_adv       = s1_valid_ff && (!s1_emit || out_free);
      req_stall    = s1_valid_ff && !s1_adv;
      accept       = req_valid && !req_stall;
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (s1_adv && s1_emit) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   bsd_cnt #(
      .MAX_COLS  (MAX_COLS),
      .MAX_SCALE (MAX_SCALE)
   ) u_cnt (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .grad_in   (req_grad_in),
      .scale_m1  (scale_m1_ff),
      .width_m1  (width_m1_ff),
      .height_m1 (height_m1_ff),
      .col       (cur_col),
      .flags     (cur_flags),
      .run_sum   (run_sum)
   );

   // run_sum only moves on accept, which also moves stage one along
   bsd_rowbuf #(
      .MAX_COLS (MAX_COLS)
   ) u_rowbuf (
      .clock     (clock),
      .rd_en     (accept),
      .rd_col    (cur_col),
      .wr_en     (s1_adv && s1_flags_ff.col_end),
      .wr_col    (s1_col_ff),
      .first_row (s1_flags_ff.first_row),
      .run_sum   (run_sum),
      .total     (total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= cur_col;
         s1_flags_ff <= cur_flags;
      end
      if (s1_adv && s1_emit) begin
         rsp_sum_ff  <= total;
         rsp_last_ff <= s1_flags_ff.plane_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_sum  = rsp_sum_ff;
   assign rsp_plane_last = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(s1_adv && s1_emit))
      else $error("result register overwritten while held");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_emit && rsp_valid && rsp_stall))
      else $error("request stalled without a blocked result");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emit) |=> (rsp_valid && (rsp_plane_last == $past(s1_flags_ff.plane_last))))
      else $error("completed block not presented on rsp");

endmodule

>>> rtl/core/bsd_cnt.sv
module bsd_cnt import bsd_pkg::*; #(
   parameter int MAX_COLS  = BSD_MAX_COLS,
   parameter int MAX_SCALE = BSD_MAX_SCALE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic signed [GRAD_W-1:0] grad_in,
   input  logic [((MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1)-1:0] scale_m1,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0]   width_m1,
   input  logic [ROW_W-1:0]         height_m1,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0]   col,
   output bsd_flags_type            flags,
   output logic signed [SUM_W-1:0]  run_sum
);

   localparam int SubW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [SubW-1:0]         sub_col_ff, sub_col_in;
   logic [SubW-1:0]         sub_row_ff, sub_row_in;
   logic [ColW-1:0]         out_col_ff, out_col_in;
   logic [ROW_W-1:0]        out_row_ff, out_row_in;
   logic signed [SUM_W-1:0] run_sum_ff, run_sum_in;
   logic                    col_end, row_end, last_col, last_row;
   logic signed [SUM_W-1:0] grad_ext;

   always_comb begin
      col_end  = sub_col_ff >= scale_m1;
      row_end  = sub_row_ff >= scale_m1;
      last_col = out_col_ff >= width_m1;
      last_row = out_row_ff >= height_m1;
      grad_ext = {{(SUM_W - GRAD_W){grad_in[GRAD_W-1]}}, grad_in};

      flags.col_end    = col_end;
      flags.row_end    = row_end;
      flags.first_row  = (sub_row_ff == '0);
      flags.plane_last = last_col && last_row;

      sub_col_in = sub_col_ff;
      sub_row_in = sub_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      run_sum_in = run_sum_ff;
      if (accept) begin
         // horizontal part of the block restarts on its first column
         run_sum_in = ((sub_col_ff == '0) ? '0 : run_sum_ff) + grad_ext;
         if (col_end) begin
            sub_col_in = '0;
            if (last_col) begin
               out_col_in = '0;
               if (row_end) begin
                  sub_row_in = '0;
                  out_row_in = last_row ? '0 : out_row_ff + ROW_W'(1);
               end else begin
                  sub_row_in = sub_row_ff + SubW'(1);
               end
            end else begin
               out_col_in = out_col_ff + ColW'(1);
            end
         end else begin
            sub_col_in = sub_col_ff + SubW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_col_ff <= '0;
         sub_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         run_sum_ff <= '0;
      end else begin
         sub_col_ff <= sub_col_in;
         sub_row_ff <= sub_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         run_sum_ff <= run_sum_in;
      end
   end

   assign col     = out_col_ff;
   assign run_sum = run_sum_ff;

endmodule

>>> rtl/core/bsd_rowbuf.sv
module bsd_rowbuf import bsd_pkg::*; #(
   parameter int MAX_COLS = BSD_MAX_COLS
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_col,
   input  logic                    wr_en,
   input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wr_col,
   input  logic                    first_row,
   input  logic signed [SUM_W-1:0] run_sum,
   output logic signed [SUM_W-1:0] total
);

   logic signed [SUM_W-1:0] mem [MAX_COLS];
   logic signed [SUM_W-1:0] rd_data_ff;
   logic signed [SUM_W-1:0] fwd_data_ff;
   logic                    fwd_ff;
   logic signed [SUM_W-1:0] partial;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_col] <= total;
      end
   end

   // a write landing on the same edge as the read is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_col];
         fwd_ff      <= wr_en && (wr_col == rd_col);
         fwd_data_ff <= total;
      end
   end

   always_comb begin
      partial = fwd_ff ? fwd_data_ff : rd_data_ff;
      total   = (first_row ? '0 : partial) + run_sum;
   end

endmodule

>>> dv/block_sum_downsample_checker.sv
`timescale 1ns / 100ps

module block_sum_downsample_checker import bsd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [GRAD_W-1:0] req_grad_in,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [SUM_W-1:0]  rsp_block_sum,
   input  logic                     rsp_plane_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,
   output int                       errors,
   output int                       pending,
   output int                       sums_checked,
   output int                       planes_seen,
   output int                       cols_written,
   output int                       plane_len,
   output logic                     at_origin,
   output logic                     fresh_row
);

   logic [SCALE_W-1:0]      scale_reg;
   logic [DIM_W-1:0]        width_reg;
   logic [DIM_W-1:0]        height_reg;
   logic signed [SUM_W-1:0] partials [BSD_MAX_COLS];
   logic signed [SUM_W-1:0] run_sum;
   int                      sub_col, sub_row, out_col, out_row;

   // block sums and plane-end flags still owed by the block, oldest first
   logic signed [SUM_W-1:0] sums_due [$];
   logic                    last_due [$];

   function automatic int bounded(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= 40) $display("%0t ns mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin : predict
      int                      s, w, h, col;
      bit                      col_end, row_end, last_col, last_row;
      logic signed [SUM_W-1:0] total, want_sum;
      logic                    want_last;
      if (reset) begin
         scale_reg    = SCALE_W'(SCALE_RESET);
         width_reg    = DIM_W'(WIDTH_RESET);
         height_reg   = DIM_W'(HEIGHT_RESET);
         sub_col      = 0;
         sub_row      = 0;
         out_col      = 0;
         out_row      = 0;
         run_sum      = '0;
         cols_written = 0;
         sums_due.delete();
         last_due.delete();
      end else begin
         // retire before predicting: a sum never belongs to a request of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (sums_due.size() == 0) begin
               note_mismatch($sformatf("block sum %0d arrived with none due", rsp_block_sum));
            end else begin
               want_sum  = sums_due.pop_front();
               want_last = last_due.pop_front();
               if (rsp_block_sum !== want_sum)
                  note_mismatch($sformatf("block_sum %0d, predicted %0d",
                                          rsp_block_sum, want_sum));
               if (rsp_plane_last !== want_last)
                  note_mismatch($sformatf("plane_last %0b, predicted %0b (sum %0d)",
                                          rsp_plane_last, want_last, want_sum));
               sums_checked++;
               if (want_last) planes_seen++;
            end
         end

         if (req_valid && !req_stall) begin
            s        = bounded(int'(scale_reg), BSD_MAX_SCALE);
            w        = bounded(int'(width_reg), BSD_MAX_COLS);
            h        = bounded(int'(height_reg), ROW_CAP);
            col      = (out_col < BSD_MAX_COLS) ? out_col : BSD_MAX_COLS - 1;
            // "reach or pass" so that shrinking a register mid-plane wraps at once
            col_end  = sub_col >= s - 1;
            row_end  = sub_row >= s - 1;
            last_col = out_col >= w - 1;
            last_row = out_row >= h - 1;

            if (sub_col == 0) run_sum = '0;
            run_sum = run_sum + SUM_W'(req_grad_in);

            if (col_end) begin
               total = (sub_row == 0) ? run_sum : partials[col] + run_sum;
               partials[col] = total;
               if (col + 1 > cols_written) cols_written = col + 1;
               if (row_end) begin
                  sums_due.push_back(total);
                  last_due.push_back(last_col && last_row);
               end
               sub_col = 0;
               if (last_col) begin
                  out_col = 0;
                  if (row_end) begin
                     sub_row = 0;
                     out_row = last_row ? 0 : out_row + 1;
                  end else begin
                     sub_row++;
                  end
               end else begin
                  out_col++;
               end
            end else begin
               sub_col++;
            end
         end

         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCALE:      scale_reg  = csr_wdata[SCALE_W-1:0];
               CSR_OUT_WIDTH:  width_reg  = csr_wdata[DIM_W-1:0];
               CSR_OUT_HEIGHT: height_reg = csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
      end

      s         = bounded(int'(scale_reg), BSD_MAX_SCALE);
      plane_len = s * s * bounded(int'(width_reg), BSD_MAX_COLS)
                      * bounded(int'(height_reg), ROW_CAP);
      pending   = sums_due.size();
      at_origin = (sub_col == 0) && (sub_row == 0) && (out_col == 0) && (out_row == 0);
      fresh_row = (sub_row == 0);
   end

endmodule

>>> dv/block_sum_downsample_tb.sv
`timescale 1ns / 100ps

module block_sum_downsample_tb;
   import bsd_pkg::*;

   // index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
   localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};
   localparam int RAND_REQUESTS = 1300;
   localparam int CYCLE_LIMIT   = 200000;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic signed [GRAD_W-1:0] req_grad_in    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic signed [SUM_W-1:0]  rsp_block_sum;
   logic                     rsp_plane_last;
   logic                     csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index      = '0;
   logic [CSR_W-1:0]         csr_wdata      = '0;

   int   errors, pending, sums_checked, planes_seen, cols_written, plane_len;
   logic at_origin, fresh_row;
   bit   quiet    = 1'b0;
   int   requests = 0;
   int   cycles   = 0;

   block_sum_downsample i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_grad_in    (req_grad_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_block_sum  (rsp_block_sum),
      .rsp_plane_last (rsp_plane_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   block_sum_downsample_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_grad_in    (req_grad_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_block_sum  (rsp_block_sum),
      .rsp_plane_last (rsp_plane_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .errors         (errors),
      .pending        (pending),
      .sums_checked   (sums_checked),
      .planes_seen    (planes_seen),
      .cols_written   (cols_written),
      .plane_len      (plane_len),
      .at_origin      (at_origin),
      .fresh_row      (fresh_row)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d block sums outstanding", cycles, pending);
         $display("[block_sum_downsample] ERROR");
         $finish;
      end
   end

   function automatic logic signed [GRAD_W-1:0] pick_grad();
      case ($urandom_range(0, 9))
         0:       pick_grad = GRAD_MAX;
         1:       pick_grad = GRAD_MIN;
         2:       pick_grad = GRAD_W'($urandom_range(0, 16)) - GRAD_W'(8);
         default: pick_grad = GRAD_W'($urandom);
      endcase
   endfunction

   // all tasks below start and end on a falling edge
   task automatic push_grad(input logic signed [GRAD_W-1:0] grad);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_grad_in <= grad;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      // a request that closes no block may still be in flight
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // upper data bits of the scale write are junk that the register drops
   task automatic set_dims(input int s, input int w, input int h);
      write_reg(CSR_SCALE, {(CSR_W-SCALE_W)'($urandom), SCALE_W'(s)});
      write_reg(CSR_OUT_WIDTH, CSR_W'(w));
      write_reg(CSR_OUT_HEIGHT, CSR_W'(h));
   endtask

   // finish whatever plane the registers left open
   task automatic realign();
      while (!at_origin) push_grad(pick_grad());
   endtask

   initial begin : stimulus
      int s, se, w, h, budget, w2, directed_reqs, phase, waited, n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one value per plane at the input extremes
      set_dims(1, 1, 1);
      push_grad(GRAD_MAX);
      push_grad(GRAD_MIN);
      push_grad('0);
      push_grad(-GRAD_W'(1));
      settle();

      // zero registers act as 1; the spare index is ignored
      set_dims(0, 0, 0);
      write_reg(CSR_SPARE, '1);
      push_grad(GRAD_W'(1));
      push_grad(GRAD_MIN);
      settle();

      // two 2x2 blocks of full-scale values
      set_dims(2, 2, 1);
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 4; c++) push_grad((c < 2) ? GRAD_MAX : GRAD_MIN);
      end
      settle();

      set_dims(1, 3, 2);
      repeat (6) push_grad(pick_grad());
      settle();

      directed_reqs = requests;
      phase = 0;
      while (requests - directed_reqs < RAND_REQUESTS) begin
         realign();
         settle();
         if (phase == 0) begin
            // oversized scale saturates to the 8x8 block
            set_dims($urandom_range(9, 15), 1, 1);
            repeat (plane_len) push_grad(pick_grad());
         end else if (phase == 1) begin
            // full row at the column limit, first half without any idling
            set_dims(1, $urandom_range(BSD_MAX_COLS, 2047), 1);
            n = plane_len;
            for (int i = 0; i < n; i++) begin
               quiet = (i < n / 2);
               push_grad(pick_grad());
            end
            quiet = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            // registers rewritten partway through a plane
            case ($urandom_range(0, 5))
               0:       w = 0;
               1:       w = 2047;
               default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 5))
               0:       h = 0;
               1:       h = ROW_CAP;
               2:       h = 2047;
               default: h = $urandom_range(1, 4);
            endcase
            set_dims($urandom_range(0, 15), w, h);
            repeat ($urandom_range(1, 40)) push_grad(pick_grad());
            settle();
            // widening is only safe over columns that hold a written partial
            w2 = $urandom_range(1, 4);
            if (!fresh_row && w2 > cols_written) w2 = cols_written;
            set_dims($urandom_range(1, 3), w2, $urandom_range(1, 2));
            repeat ($urandom_range(1, 30)) push_grad(pick_grad());
         end else begin
            case ($urandom_range(0, 9))
               0:       s = 0;
               1:       s = $urandom_range(9, 15);
               2, 3:    s = $urandom_range(4, BSD_MAX_SCALE);
               default: s = $urandom_range(1, 3);
            endcase
            se = (s < 1) ? 1 : ((s > BSD_MAX_SCALE) ? BSD_MAX_SCALE : s);
            // keep planes near 64 requests at most
            budget = 64 / (se * se);
            if (budget < 1) budget = 1;
            w = $urandom_range(1, (budget < 6) ? budget : 6);
            budget = budget / w;
            if (budget < 1) budget = 1;
            h = $urandom_range(1, (budget < 3) ? budget : 3);
            if ($urandom_range(0, 9) == 0) w = 0;
            if ($urandom_range(0, 9) == 0) h = 0;
            set_dims(s, w, h);
            repeat (plane_len) push_grad(pick_grad());
         end
         phase++;
      end

      req_valid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 1000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);

      $display("%0d requests in %0d phases, %0d block sums checked, %0d planes closed",
               requests, phase, sums_checked, planes_seen);
      $display("scales 0..15, widths up to the column limit, mid-plane register rewrites");
      if (pending != 0) $display("%0d block sums never arrived", pending);
      if (errors == 0 && pending == 0) begin
         $display("[block_sum_downsample] OK");
      end else begin
         $display("[block_sum_downsample] ERROR");
      end
      $finish;
   end

endmodule

>>> block_sum_downsample.f
rtl/core/bsd_pkg.sv
rtl/core/bsd_cnt.sv
rtl/core/bsd_rowbuf.sv
rtl/core/block_sum_downsample.sv
dv/block_sum_downsample_checker.sv
dv/block_sum_downsample_tb.sv
